/* rtl/assert_macros.svh */
// Assertion macros used by the core RTL file for its checks.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

/* rtl/epq_pkg.sv */
// Types, character codes and helper functions of the position query responder.
// Has no dependencies; every RTL module refers to it by scoped names.
package epq_pkg;

    localparam int MAG_W = 17;
    localparam int BCD_W = 20;
    localparam int CNT_W = 5;
    localparam int IDX_W = 4;
    localparam int FIFO_AW = 1;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    localparam logic [MAG_W-1:0] POS_LIMIT = 17'd99999;
    localparam logic [15:0] CPR_RESET = 16'd4096;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_SP = 8'h20;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CMD_Q_UP = 8'h51;
    localparam logic [7:0] CMD_Q_LO = 8'h71;
    localparam logic [7:0] CMD_H_UP = 8'h48;
    localparam logic [7:0] CMD_H_LO = 8'h68;

    localparam logic [CNT_W-1:0] CONV_LAST = 5'd16;
    localparam logic [IDX_W-1:0] IDX_POS_LAST = 4'd13;
    localparam logic [IDX_W-1:0] IDX_RES_LAST = 4'd11;

    typedef enum logic {
        OP_POS,
        OP_RES
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CONV,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        op_t              op;
        logic             az_neg;
        logic [MAG_W-1:0] az_mag;
        logic             alt_neg;
        logic [MAG_W-1:0] alt_mag;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [MAG_W-1:0] sat_mag(input logic [17:0] v);
        logic [17:0] mag;
        mag = v[17] ? (~v + 18'd1) : v;
        return (mag > {1'b0, POS_LIMIT}) ? POS_LIMIT : mag[MAG_W-1:0];
    endfunction

    function automatic logic [BCD_W-1:0] bcd_step(input logic [BCD_W-1:0] bcd,
                                                   input logic bit_in);
        logic [BCD_W-1:0] adj;
        logic [3:0] nib;
        for (int i = 0; i < BCD_W / 4; i++) begin
            nib = bcd[4*i +: 4];
            adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    function automatic logic [7:0] digit_char(input logic [BCD_W-1:0] bcd,
                                              input logic [2:0] pos);
        logic [3:0] nib;
        unique case (pos)
            3'd0: nib = bcd[3:0];
            3'd1: nib = bcd[7:4];
            3'd2: nib = bcd[11:8];
            3'd3: nib = bcd[15:12];
            3'd4: nib = bcd[19:16];
            default: nib = 4'd0;
        endcase
        return CHAR_ZERO + {4'd0, nib};
    endfunction

endpackage

/* rtl/epq_front.sv */
// Front end: takes received bytes, tracks the chunk, and queues served commands.
// Depends on epq_pkg.
module epq_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [7:0]           rx_byte,
    input  logic                 chunk_last,
    input  logic signed [17:0]   azimuth_count,
    input  logic signed [17:0]   altitude_count,
    input  epq_pkg::q_status_t   q_stat,
    output logic                 full,
    output logic                 q_push,
    output epq_pkg::cmd_t        q_wdata
);

    logic chunk_served_reg;
    logic chunk_served_next;
    logic accept;
    logic framing;
    logic is_pos;
    logic is_res;
    logic serve;

    assign full = q_stat.full;
    assign accept = push && !q_stat.full;

    always_comb
    begin
        framing = (rx_byte == epq_pkg::CHAR_CR) || (rx_byte == epq_pkg::CHAR_LF) ||
                  (rx_byte == epq_pkg::CHAR_SP) || (rx_byte == epq_pkg::CHAR_TAB) ||
                  (rx_byte == epq_pkg::CHAR_NUL);
        is_pos = (rx_byte == epq_pkg::CMD_Q_UP) || (rx_byte == epq_pkg::CMD_Q_LO);
        is_res = (rx_byte == epq_pkg::CMD_H_UP) || (rx_byte == epq_pkg::CMD_H_LO);
        serve = accept && !chunk_served_reg && !framing;

        chunk_served_next = chunk_served_reg;
        if (serve)
        begin
            chunk_served_next = 1'b1;
        end
        if (accept && chunk_last)
        begin
            chunk_served_next = 1'b0;
        end

        q_push = serve && (is_pos || is_res);
        q_wdata.op = is_pos ? epq_pkg::OP_POS : epq_pkg::OP_RES;
        q_wdata.az_neg = azimuth_count[17];
        q_wdata.az_mag = epq_pkg::sat_mag($unsigned(azimuth_count));
        q_wdata.alt_neg = altitude_count[17];
        q_wdata.alt_mag = epq_pkg::sat_mag($unsigned(altitude_count));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_served_reg <= 1'b0;
        end
        else
        begin
            chunk_served_reg <= chunk_served_next;
        end
    end

endmodule

/* rtl/epq_fifo.sv */
// Short command queue between the front end and the reply generator.
// Depends on epq_pkg.
module epq_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  epq_pkg::cmd_t        wr_data,
    input  logic                 rd_en,
    output epq_pkg::cmd_t        rd_data,
    output epq_pkg::q_status_t   stat
);

    epq_pkg::cmd_t mem [epq_pkg::FIFO_DEPTH];
    epq_pkg::cmd_t rd_data_reg;
    logic [epq_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [epq_pkg::FIFO_AW-1:0] wr_ptr_next;
    logic [epq_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [epq_pkg::FIFO_AW-1:0] rd_ptr_next;
    logic [epq_pkg::FIFO_AW:0]   count_reg;
    logic [epq_pkg::FIFO_AW:0]   count_next;
    logic                        do_wr;
    logic                        do_rd;

    assign rd_data = rd_data_reg;

    always_comb
    begin
        stat.full = (count_reg == (epq_pkg::FIFO_AW + 1)'(epq_pkg::FIFO_DEPTH));
        stat.empty = (count_reg == '0);
        do_wr = wr_en && !stat.full;
        do_rd = rd_en && !stat.empty;
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (do_wr && (wr_ptr_reg == rd_ptr_next))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_ptr_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/epq_back.sv */
// Reply generator: converts counts to decimal and sends the reply one byte at a time.
// Depends on epq_pkg.
module epq_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  epq_pkg::q_status_t   q_stat,
    input  epq_pkg::cmd_t        q_rdata,
    output logic                 q_pop,
    input  logic [15:0]          counts_per_rev,
    output logic [7:0]           tx_byte,
    output logic                 reply_last,
    output logic                 empty,
    input  logic                 pop
);

    epq_pkg::back_state_t state_reg;
    epq_pkg::back_state_t state_next;
    logic [epq_pkg::CNT_W-1:0] cnt_reg;
    logic [epq_pkg::CNT_W-1:0] cnt_next;
    epq_pkg::op_t op_reg;
    epq_pkg::op_t op_next;
    logic a_neg_reg;
    logic a_neg_next;
    logic b_neg_reg;
    logic b_neg_next;
    logic [epq_pkg::MAG_W-1:0] a_shift_reg;
    logic [epq_pkg::MAG_W-1:0] a_shift_next;
    logic [epq_pkg::MAG_W-1:0] b_shift_reg;
    logic [epq_pkg::MAG_W-1:0] b_shift_next;
    logic [epq_pkg::BCD_W-1:0] a_bcd_reg;
    logic [epq_pkg::BCD_W-1:0] a_bcd_next;
    logic [epq_pkg::BCD_W-1:0] b_bcd_reg;
    logic [epq_pkg::BCD_W-1:0] b_bcd_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic [7:0] tx_byte_reg;
    logic [7:0] tx_byte_next;
    logic reply_last_reg;
    logic reply_last_next;

    logic [epq_pkg::IDX_W-1:0] idx;
    logic [epq_pkg::IDX_W-1:0] idx_end;
    logic [4:0] lead;
    logic [7:0] cur_byte;
    logic cur_emit;
    logic cur_last;
    logic slot_free;
    logic step_ok;
    logic out_pop;

    assign tx_byte = tx_byte_reg;
    assign reply_last = reply_last_reg;
    assign empty = !out_valid_reg;
    assign out_pop = pop && out_valid_reg;
    assign slot_free = !out_valid_reg || pop;
    assign idx = cnt_reg[epq_pkg::IDX_W-1:0];

    always_comb
    begin
        lead[4] = |a_bcd_reg[19:16];
        lead[3] = lead[4] || (|a_bcd_reg[15:12]);
        lead[2] = lead[3] || (|a_bcd_reg[11:8]);
        lead[1] = lead[2] || (|a_bcd_reg[7:4]);
        lead[0] = 1'b1;
        cur_byte = epq_pkg::CHAR_CR;
        cur_emit = 1'b1;
        cur_last = 1'b0;
        if (op_reg == epq_pkg::OP_POS)
        begin
            idx_end = epq_pkg::IDX_POS_LAST;
            case (idx) inside
                4'd0: cur_byte = a_neg_reg ? epq_pkg::CHAR_MINUS : epq_pkg::CHAR_PLUS;
                [4'd1:4'd5]: cur_byte = epq_pkg::digit_char(a_bcd_reg, 3'(4'd5 - idx));
                4'd6: cur_byte = epq_pkg::CHAR_TAB;
                4'd7: cur_byte = b_neg_reg ? epq_pkg::CHAR_MINUS : epq_pkg::CHAR_PLUS;
                [4'd8:4'd12]: cur_byte = epq_pkg::digit_char(b_bcd_reg, 3'(4'd12 - idx));
                default:
                begin
                    cur_byte = epq_pkg::CHAR_CR;
                    cur_last = 1'b1;
                end
            endcase
        end
        else
        begin
            idx_end = epq_pkg::IDX_RES_LAST;
            case (idx) inside
                [4'd0:4'd4]:
                begin
                    cur_byte = epq_pkg::digit_char(a_bcd_reg, 3'(4'd4 - idx));
                    cur_emit = lead[3'(4'd4 - idx)];
                end
                4'd5: cur_byte = epq_pkg::CHAR_SP;
                [4'd6:4'd10]:
                begin
                    cur_byte = epq_pkg::digit_char(a_bcd_reg, 3'(4'd10 - idx));
                    cur_emit = lead[3'(4'd10 - idx)];
                end
                default:
                begin
                    cur_byte = epq_pkg::CHAR_CR;
                    cur_last = 1'b1;
                end
            endcase
        end
        step_ok = !cur_emit || slot_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            epq_pkg::BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = epq_pkg::BK_CONV;
                end
            end
            epq_pkg::BK_CONV:
            begin
                if (cnt_reg == epq_pkg::CONV_LAST)
                begin
                    state_next = epq_pkg::BK_EMIT;
                end
            end
            epq_pkg::BK_EMIT:
            begin
                if (step_ok && (idx == idx_end))
                begin
                    state_next = epq_pkg::BK_IDLE;
                end
            end
            default: state_next = epq_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = 1'b0;
        cnt_next = cnt_reg;
        op_next = op_reg;
        a_neg_next = a_neg_reg;
        b_neg_next = b_neg_reg;
        a_shift_next = a_shift_reg;
        b_shift_next = b_shift_reg;
        a_bcd_next = a_bcd_reg;
        b_bcd_next = b_bcd_reg;
        out_valid_next = out_valid_reg && !out_pop;
        tx_byte_next = tx_byte_reg;
        reply_last_next = reply_last_reg;
        unique case (state_reg)
            epq_pkg::BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop = 1'b1;
                    cnt_next = '0;
                    op_next = q_rdata.op;
                    a_neg_next = q_rdata.az_neg;
                    b_neg_next = q_rdata.alt_neg;
                    a_shift_next = (q_rdata.op == epq_pkg::OP_POS) ? q_rdata.az_mag :
                                   {1'b0, counts_per_rev};
                    b_shift_next = q_rdata.alt_mag;
                    a_bcd_next = '0;
                    b_bcd_next = '0;
                end
            end
            epq_pkg::BK_CONV:
            begin
                a_bcd_next = epq_pkg::bcd_step(a_bcd_reg, a_shift_reg[epq_pkg::MAG_W-1]);
                b_bcd_next = epq_pkg::bcd_step(b_bcd_reg, b_shift_reg[epq_pkg::MAG_W-1]);
                a_shift_next = {a_shift_reg[epq_pkg::MAG_W-2:0], 1'b0};
                b_shift_next = {b_shift_reg[epq_pkg::MAG_W-2:0], 1'b0};
                cnt_next = (cnt_reg == epq_pkg::CONV_LAST) ? '0 : cnt_reg + 1'b1;
            end
            epq_pkg::BK_EMIT:
            begin
                if (step_ok)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cur_emit)
                    begin
                        out_valid_next = 1'b1;
                        tx_byte_next = cur_byte;
                        reply_last_next = cur_last;
                    end
                end
            end
            default: q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        a_neg_reg <= a_neg_next;
        b_neg_reg <= b_neg_next;
        a_shift_reg <= a_shift_next;
        b_shift_reg <= b_shift_next;
        a_bcd_reg <= a_bcd_next;
        b_bcd_reg <= b_bcd_next;
        tx_byte_reg <= tx_byte_next;
        reply_last_reg <= reply_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= epq_pkg::BK_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/encoder_position_query_responder_core.sv */
// Position query responder: received bytes in, ASCII reply bytes out.
// Input side is a queue port (push/full): one received byte per transfer, with
// chunk_last marking the final byte of a receive chunk and the two axis counts
// sampled with it. Output side is a queue port (empty/pop): one reply byte per
// transfer, with reply_last high on the closing CR.
// Framing and ignored bytes are taken one per cycle while the command queue
// is not full. A position or resolution command enters a two-entry command
// queue; full rises only when that queue is full. The reply generator takes
// one command at a time, runs a binary to decimal conversion, then walks the
// reply byte slots one per cycle while the output register can take a byte;
// once the CR is loaded it returns to idle, where it pops the next command.
// The conversion loop and the single output register set the rate. When the
// receiver stalls, the output register holds its byte and the reply generator
// waits; commands keep queuing until the queue is full.
// After reset no reply is pending, the chunk starts fresh and the resolution
// register holds 4096. The register is written through cfg_we and cfg_data.
// Depends on epq_pkg, epq_front, epq_fifo, epq_back and assert_macros.svh.
`include "assert_macros.svh"
module encoder_position_query_responder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          rx_byte,
    input  logic                chunk_last,
    input  logic signed [17:0]  azimuth_count,
    input  logic signed [17:0]  altitude_count,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data,
    output logic [7:0]          tx_byte,
    output logic                reply_last,
    output logic                empty,
    input  logic                pop
);

    logic [15:0] counts_per_rev_reg;
    logic [15:0] counts_per_rev_next;
    logic q_push;
    logic q_pop;
    epq_pkg::cmd_t q_wdata;
    epq_pkg::cmd_t q_rdata;
    epq_pkg::q_status_t q_stat;

    assign counts_per_rev_next = cfg_we ? cfg_data : counts_per_rev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_per_rev_reg <= epq_pkg::CPR_RESET;
        end
        else
        begin
            counts_per_rev_reg <= counts_per_rev_next;
        end
    end

    epq_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .rx_byte        (rx_byte),
        .chunk_last     (chunk_last),
        .azimuth_count  (azimuth_count),
        .altitude_count (altitude_count),
        .q_stat         (q_stat),
        .full           (full),
        .q_push         (q_push),
        .q_wdata        (q_wdata)
    );

    epq_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .stat    (q_stat)
    );

    epq_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .q_rdata        (q_rdata),
        .q_pop          (q_pop),
        .counts_per_rev (counts_per_rev_reg),
        .tx_byte        (tx_byte),
        .reply_last     (reply_last),
        .empty          (empty),
        .pop            (pop)
    );

    `ASSERT_NEVER(a_queue_no_overflow, q_push && q_stat.full)
    `ASSERT_NEVER(a_queue_no_underflow, q_pop && q_stat.empty)
    `ASSERT_CLK(a_last_is_cr, !empty && reply_last |-> tx_byte == epq_pkg::CHAR_CR)

endmodule

/* sim/encoder_position_query_responder_core_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for encoder_position_query_responder_core.
// Predicts every reply byte from the received bytes, the axis counts and the
// resolution setting. Depends on epq_pkg and the core RTL.
module encoder_position_query_responder_core_test;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } reply_byte_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [7:0]         rx_byte = 8'd0;
    logic               chunk_last = 1'b0;
    logic signed [17:0] azimuth_count = '0;
    logic signed [17:0] altitude_count = '0;
    logic               cfg_we = 1'b0;
    logic [15:0]        cfg_data = 16'd0;
    logic [7:0]         tx_byte;
    logic               reply_last;
    logic               empty;
    logic               pop = 1'b0;

    reply_byte_t pending_reply[$];
    logic [15:0] model_cpr = epq_pkg::CPR_RESET;
    logic        model_chunk_served = 1'b0;
    logic        gaps_on = 1'b1;
    int          mismatch_count = 0;
    int          sent_count = 0;

    encoder_position_query_responder_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .rx_byte        (rx_byte),
        .chunk_last     (chunk_last),
        .azimuth_count  (azimuth_count),
        .altitude_count (altitude_count),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .tx_byte        (tx_byte),
        .reply_last     (reply_last),
        .empty          (empty),
        .pop            (pop)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic is_framing(input logic [7:0] c);
        return c == epq_pkg::CHAR_CR || c == epq_pkg::CHAR_LF || c == epq_pkg::CHAR_SP ||
               c == epq_pkg::CHAR_TAB || c == epq_pkg::CHAR_NUL;
    endfunction

    function automatic void add_reply_byte(input logic [7:0] c, input logic last);
        reply_byte_t entry;
        entry.ch = c;
        entry.last = last;
        pending_reply.push_back(entry);
    endfunction

    function automatic void add_count_field(input logic signed [17:0] count);
        int         value;
        int         mag;
        int         scale;
        logic [7:0] digit;
        value = count;
        if (value > 99999)
            value = 99999;
        if (value < -99999)
            value = -99999;
        add_reply_byte(value < 0 ? epq_pkg::CHAR_MINUS : epq_pkg::CHAR_PLUS, 1'b0);
        mag = value < 0 ? -value : value;
        scale = 10000;
        while (scale > 0)
        begin
            digit = 8'(mag / scale % 10);
            add_reply_byte(epq_pkg::CHAR_ZERO + digit, 1'b0);
            scale = scale / 10;
        end
    endfunction

    function automatic void add_plain_number(input logic [15:0] number);
        int         rest;
        int         scale;
        logic [7:0] digit;
        rest = number;
        scale = 1;
        while (scale * 10 <= rest)
            scale = scale * 10;
        while (scale > 0)
        begin
            digit = 8'(rest / scale % 10);
            add_reply_byte(epq_pkg::CHAR_ZERO + digit, 1'b0);
            scale = scale / 10;
        end
    endfunction

    function automatic void predict_reply(input logic [7:0] c, input logic last,
                                          input logic signed [17:0] az,
                                          input logic signed [17:0] alt);
        if (!model_chunk_served && !is_framing(c))
        begin
            model_chunk_served = 1'b1;
            if (c == epq_pkg::CMD_Q_UP || c == epq_pkg::CMD_Q_LO)
            begin
                add_count_field(az);
                add_reply_byte(epq_pkg::CHAR_TAB, 1'b0);
                add_count_field(alt);
                add_reply_byte(epq_pkg::CHAR_CR, 1'b1);
            end
            else if (c == epq_pkg::CMD_H_UP || c == epq_pkg::CMD_H_LO)
            begin
                add_plain_number(model_cpr);
                add_reply_byte(epq_pkg::CHAR_SP, 1'b0);
                add_plain_number(model_cpr);
                add_reply_byte(epq_pkg::CHAR_CR, 1'b1);
            end
        end
        if (last)
            model_chunk_served = 1'b0;
    endfunction

    always @(posedge clk)
    begin : check_reply
        reply_byte_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_reply.size() == 0)
            begin
                $display("%0t: unexpected reply byte, expected none, actual %h last %b",
                         $time, tx_byte, reply_last);
                mismatch_count++;
            end
            else
            begin
                want = pending_reply.pop_front();
                if (tx_byte !== want.ch)
                begin
                    $display("%0t: tx_byte expected %h actual %h", $time, want.ch, tx_byte);
                    mismatch_count++;
                end
                if (reply_last !== want.last)
                begin
                    $display("%0t: reply_last expected %b actual %b",
                             $time, want.last, reply_last);
                    mismatch_count++;
                end
            end
        end
        pop <= !gaps_on || ($urandom_range(0, 99) >= 20);
    end

    task automatic send_byte(input logic [7:0] c, input logic last,
                             input logic signed [17:0] az, input logic signed [17:0] alt);
        while (gaps_on && $urandom_range(0, 99) < 20)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        rx_byte <= c;
        chunk_last <= last;
        azimuth_count <= az;
        altitude_count <= alt;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent_count++;
        predict_reply(c, last, az, alt);
    endtask

    task automatic wait_replies_done();
        push <= 1'b0;
        while (pending_reply.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_cpr(input logic [15:0] value);
        wait_replies_done();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_cpr = value;
    endtask

    function automatic logic signed [17:0] random_count();
        int value;
        case ($urandom_range(0, 3))
            0: value = $urandom;
            3: value = $urandom_range(99990, 100010);
            default: value = $urandom_range(0, 199998) - 99999;
        endcase
        if (value > 0 && value < 131072 && $urandom_range(0, 1) == 1)
            value = -value;
        return 18'(value);
    endfunction

    function automatic logic [7:0] random_framing();
        case ($urandom_range(0, 4))
            0: return epq_pkg::CHAR_CR;
            1: return epq_pkg::CHAR_LF;
            2: return epq_pkg::CHAR_SP;
            3: return epq_pkg::CHAR_TAB;
            default: return epq_pkg::CHAR_NUL;
        endcase
    endfunction

    task automatic test_position_replies();
        send_byte(epq_pkg::CMD_Q_UP, 1'b1, 18'sd0, 18'sd0);
        send_byte(epq_pkg::CMD_Q_LO, 1'b1, 18'sd99999, -18'sd99999);
        send_byte(epq_pkg::CMD_Q_UP, 1'b1, -18'sd1, 18'sd1);
        send_byte(epq_pkg::CMD_Q_UP, 1'b1, 18'sd131071, 18'sh20000);
        send_byte(epq_pkg::CMD_Q_LO, 1'b1, 18'sd100000, -18'sd100000);
        send_byte(epq_pkg::CMD_Q_UP, 1'b1, 18'sd12345, -18'sd678);
    endtask

    task automatic test_resolution_replies();
        send_byte(epq_pkg::CMD_H_UP, 1'b1, random_count(), random_count());
        send_byte(epq_pkg::CMD_H_LO, 1'b1, random_count(), random_count());
        write_cpr(16'd1);
        send_byte(epq_pkg::CMD_H_UP, 1'b1, random_count(), random_count());
        write_cpr(16'd65535);
        send_byte(epq_pkg::CMD_H_LO, 1'b1, random_count(), random_count());
        write_cpr(16'd0);
        send_byte(epq_pkg::CMD_H_UP, 1'b1, random_count(), random_count());
        write_cpr(epq_pkg::CPR_RESET);
    endtask

    task automatic test_chunk_framing();
        send_byte(epq_pkg::CHAR_NUL, 1'b0, 18'sd0, 18'sd0);
        send_byte(epq_pkg::CHAR_CR, 1'b0, 18'sd0, 18'sd0);
        send_byte(epq_pkg::CHAR_LF, 1'b0, 18'sd0, 18'sd0);
        send_byte(epq_pkg::CHAR_SP, 1'b0, 18'sd0, 18'sd0);
        send_byte(epq_pkg::CHAR_TAB, 1'b0, 18'sd0, 18'sd0);
        send_byte(epq_pkg::CMD_Q_UP, 1'b0, -18'sd4321, 18'sd98765);
        send_byte(epq_pkg::CMD_H_UP, 1'b0, 18'sd0, 18'sd0);
        send_byte(8'h78, 1'b1, 18'sd0, 18'sd0);
        send_byte(8'h5A, 1'b0, 18'sd5, 18'sd5);
        send_byte(epq_pkg::CMD_Q_UP, 1'b1, 18'sd5, 18'sd5);
        send_byte(epq_pkg::CHAR_SP, 1'b1, 18'sd0, 18'sd0);
        send_byte(epq_pkg::CMD_H_LO, 1'b1, 18'sd0, 18'sd0);
        send_byte(8'hFF, 1'b1, 18'sd0, 18'sd0);
    endtask

    task automatic send_random_chunk();
        int         count;
        int         k;
        logic [7:0] command;
        if ($urandom_range(0, 9) == 0)
        begin
            count = $urandom_range(1, 4);
            for (k = 0; k < count; k++)
                send_byte(8'($urandom), 1'($urandom_range(0, 1)), random_count(),
                          random_count());
        end
        else
        begin
            count = $urandom_range(0, 3);
            for (k = 0; k < count; k++)
                send_byte(random_framing(), 1'b0, random_count(), random_count());
            case ($urandom_range(0, 9))
                0, 1: command = epq_pkg::CMD_Q_UP;
                2, 3: command = epq_pkg::CMD_Q_LO;
                4, 5: command = epq_pkg::CMD_H_UP;
                6: command = epq_pkg::CMD_H_LO;
                default: command = 8'($urandom);
            endcase
            count = $urandom_range(0, 2);
            send_byte(command, count == 0, random_count(), random_count());
            for (k = 0; k < count; k++)
                send_byte(8'($urandom), k == count - 1, random_count(), random_count());
        end
    endtask

    task automatic test_random_traffic();
        int   phase;
        int   start;
        logic paused;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_cpr(16'($urandom_range(1, 65535)));
                1: write_cpr(16'd65535);
                2: write_cpr(16'($urandom_range(1, 9)));
                3: write_cpr(16'd1);
                4: write_cpr(16'($urandom_range(10, 9999)));
                default: write_cpr(epq_pkg::CPR_RESET);
            endcase
            gaps_on = (phase != 3);
            start = sent_count;
            paused = 1'b0;
            while (sent_count < start + 46)
            begin
                send_random_chunk();
                if (phase == 1 && !paused && sent_count >= start + 23)
                begin
                    wait_replies_done();
                    paused = 1'b1;
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_position_replies();
        test_resolution_replies();
        test_chunk_framing();
        test_random_traffic();
        wait_replies_done();
        if (mismatch_count == 0 && pending_reply.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* encoder_position_query_responder_core.f */
+incdir+rtl
rtl/epq_pkg.sv
rtl/epq_front.sv
rtl/epq_fifo.sv
rtl/epq_back.sv
rtl/encoder_position_query_responder_core.sv
sim/encoder_position_query_responder_core_test.sv
